@@ hw/rtl/ehcs_pkg.sv @@
// Shared constants, codes and types of the heat conduction sweep core.
package ehcs_pkg;

  // fixed-point format of the coefficients
  localparam int Q_FRAC     = 16;
  localparam int FO_BITS    = 16;
  localparam int BI_BITS    = 24;

  // digit-serial multiplier: coefficient taken 8 bits per step, MSB first
  localparam int DIGIT_BITS = 8;
  localparam int K_BITS     = 24;
  localparam int NDIG       = K_BITS / DIGIT_BITS;
  localparam int CNT_BITS   = $clog2(NDIG);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FOURIER = 3'd0,
    CFG_BIOT    = 3'd1,
    CFG_COOLANT = 3'd2,
    CFG_SOURCE  = 3'd3,
    CFG_TOL     = 3'd4
  } cfg_idx_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hw/rtl/ehcs_queue.sv @@
// Short job queue that decouples the node front end from the arithmetic back end.
module ehcs_queue
  import ehcs_pkg::*;
#(
  parameter int W = 97
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output q_stat_t      stat
);

  logic [W-1:0]         slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (count_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/ehcs_front.sv @@
// Front end: takes node words, tracks the stencil window and issues update jobs.
module ehcs_front
  import ehcs_pkg::*;
#(
  parameter int TEMP_BITS = 32,
  parameter int JOB_W     = 3*TEMP_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [TEMP_BITS-1:0] in_node_temp,
  input  logic                        in_is_last_node,
  input  q_stat_t                     q_stat,
  output logic                        q_push,
  output logic [JOB_W-1:0]            q_data
);

  // job layout: {surface, inner, node, outer}
  logic signed [TEMP_BITS-1:0] older_r, older_nxt;
  logic signed [TEMP_BITS-1:0] middle_r, middle_nxt;
  logic [1:0]                  seen_r, seen_nxt;
  logic                        pend_r, pend_nxt;
  logic [JOB_W-1:0]            pend_job_r, pend_job_nxt;
  logic                        accept;
  logic signed [TEMP_BITS-1:0] inner;

  assign in_ready = !pend_r && !q_stat.full;
  assign accept   = in_valid && in_ready;
  // the second node of a sweep mirrors itself as the centre's inner neighbour
  assign inner    = (seen_r == 2'd1) ? in_node_temp : older_r;

  always_comb begin
    older_nxt    = older_r;
    middle_nxt   = middle_r;
    seen_nxt     = seen_r;
    pend_nxt     = pend_r;
    pend_job_nxt = pend_job_r;
    q_push       = 1'b0;
    q_data       = pend_job_r;
    if (pend_r) begin
      q_push = !q_stat.full;
      if (!q_stat.full) begin
        pend_nxt = 1'b0;
      end
    end else if (accept) begin
      if (seen_r == 2'd0) begin
        if (in_is_last_node) begin
          // lone node: surface update with itself as inner neighbour
          q_push = 1'b1;
          q_data = {1'b1, in_node_temp, in_node_temp, in_node_temp};
        end else begin
          middle_nxt = in_node_temp;
          seen_nxt   = 2'd1;
        end
      end else begin
        q_push = 1'b1;
        q_data = {1'b0, inner, middle_r, in_node_temp};
        if (in_is_last_node) begin
          pend_nxt     = 1'b1;
          pend_job_nxt = {1'b1, middle_r, in_node_temp, in_node_temp};
          seen_nxt     = 2'd0;
        end else begin
          older_nxt  = middle_r;
          middle_nxt = in_node_temp;
          seen_nxt   = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      pend_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    older_r    <= older_nxt;
    middle_r   <= middle_nxt;
    pend_job_r <= pend_job_nxt;
  end

endmodule

@@ hw/rtl/ehcs_back.sv @@
// Back end: digit-serial stencil arithmetic, saturation and convergence tracking.
module ehcs_back
  import ehcs_pkg::*;
#(
  parameter int TEMP_BITS = 32,
  parameter int JOB_W     = 3*TEMP_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  q_stat_t                     q_stat,
  input  logic [JOB_W-1:0]            q_data,
  output logic                        q_pop,
  input  logic [FO_BITS-1:0]          fourier,
  input  logic [BI_BITS-1:0]          biot,
  input  logic signed [TEMP_BITS-1:0] coolant,
  input  logic signed [TEMP_BITS-1:0] source,
  input  logic [TEMP_BITS-2:0]        tol,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [TEMP_BITS-1:0] out_new_temp,
  output logic                        out_last_of_sweep,
  output logic                        out_sweep_converged
);

  localparam int TW = TEMP_BITS;
  localparam int XW = TW + 11;        // widest bracket, convective term included
  localparam int PW = XW + K_BITS;    // full product
  localparam int RW = XW + 1;         // node plus scaled bracket
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (Q_FRAC - 1);
  localparam logic signed [RW-1:0] TMAX = RW'({1'b0, {(TW-1){1'b1}}});
  localparam logic signed [RW-1:0] TMIN = -TMAX - RW'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_BRK  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  conv_ph_r, conv_ph_nxt;
  logic                  all_within_r, all_within_nxt;
  logic                  surf_r, surf_nxt;
  logic signed [TW-1:0]  a_r, a_nxt;
  logic signed [TW-1:0]  m_r, m_nxt;
  logic signed [XW-1:0]  mx_r, mx_nxt;
  logic [K_BITS-1:0]     kd_r, kd_nxt;
  logic signed [PW-1:0]  acc_r, acc_nxt;
  logic                  ov_r, ov_nxt;
  logic signed [TW-1:0]  ot_r, ot_nxt;
  logic                  ol_r, ol_nxt;
  logic                  oc_r, oc_nxt;

  logic                  q_surf;
  logic signed [TW-1:0]  q_a, q_m, q_n;
  logic signed [XW+8:0]  pp;
  logic signed [PW-1:0]  rsum;
  logic signed [XW-1:0]  rnd;
  logic signed [RW-1:0]  raw, sat;
  logic signed [TW-1:0]  t_new;
  logic signed [TW:0]    diff;
  logic [TW:0]           adiff;
  logic                  tol_ok;
  logic                  out_free;

  assign {q_surf, q_a, q_m, q_n} = q_data;

  assign pp    = mx_r * $signed({1'b0, kd_r[K_BITS-1 -: DIGIT_BITS]});
  // round to nearest, halves toward +infinity
  assign rsum  = acc_r + HALF;
  assign rnd   = rsum[Q_FRAC +: XW];
  assign raw   = RW'(m_r) + RW'(rnd);
  assign sat   = (raw > TMAX) ? TMAX : ((raw < TMIN) ? TMIN : raw);
  assign t_new = sat[TW-1:0];
  assign diff  = (TW+1)'(t_new) - (TW+1)'(m_r);
  assign adiff = diff[TW] ? (TW+1)'(-diff) : (TW+1)'(diff);
  assign tol_ok = (adiff <= {2'b00, tol});
  assign out_free = !ov_r || out_ready;

  assign q_pop = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    conv_ph_nxt    = conv_ph_r;
    all_within_nxt = all_within_r;
    surf_nxt       = surf_r;
    a_nxt          = a_r;
    m_nxt          = m_r;
    mx_nxt         = mx_r;
    kd_nxt         = kd_r;
    acc_nxt        = acc_r;
    ov_nxt         = ov_r && !out_ready;
    ot_nxt         = ot_r;
    ol_nxt         = ol_r;
    oc_nxt         = oc_r;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          surf_nxt = q_surf;
          a_nxt    = q_a;
          m_nxt    = q_m;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          if (q_surf) begin
            // convective term first: 2*(Tc - m) times Bi
            mx_nxt      = (XW'(coolant) - XW'(q_m)) <<< 1;
            kd_nxt      = K_BITS'(biot);
            conv_ph_nxt = 1'b1;
          end else begin
            mx_nxt      = XW'(q_a) + XW'(q_n) + XW'(source) - (XW'(q_m) <<< 1);
            kd_nxt      = K_BITS'(fourier);
            conv_ph_nxt = 1'b0;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        acc_nxt = (acc_r <<< DIGIT_BITS) + PW'(pp);
        kd_nxt  = kd_r << DIGIT_BITS;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(NDIG - 1)) begin
          state_nxt = conv_ph_r ? S_BRK : S_FIN;
        end
      end
      S_BRK: begin
        mx_nxt      = ((XW'(a_r) - XW'(m_r)) <<< 1) + XW'(source) + rnd;
        kd_nxt      = K_BITS'(fourier);
        acc_nxt     = '0;
        cnt_nxt     = '0;
        conv_ph_nxt = 1'b0;
        state_nxt   = S_MUL;
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ot_nxt = t_new;
          ol_nxt = surf_r;
          oc_nxt = surf_r && all_within_r && tol_ok;
          // restart the tally at the end of a sweep
          all_within_nxt = surf_r ? 1'b1 : (all_within_r && tol_ok);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      conv_ph_r    <= 1'b0;
      all_within_r <= 1'b1;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      conv_ph_r    <= conv_ph_nxt;
      all_within_r <= all_within_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    surf_r <= surf_nxt;
    a_r    <= a_nxt;
    m_r    <= m_nxt;
    mx_r   <= mx_nxt;
    kd_r   <= kd_nxt;
    acc_r  <= acc_nxt;
    ot_r   <= ot_nxt;
    ol_r   <= ol_nxt;
    oc_r   <= oc_nxt;
  end

  assign out_valid           = ov_r;
  assign out_new_temp        = ot_r;
  assign out_last_of_sweep   = ol_r;
  assign out_sweep_converged = oc_r;

endmodule

@@ hw/rtl/explicit_heat_conduction_sweep_core.sv @@
// Explicit 1-D heat conduction sweep core: one FTCS time step over a rod's radial nodes.
//
// Node temperatures enter centre first, one word per handshake, and the surface node
// carries is_last_node. Each node's updated temperature leaves one node late; the
// surface result follows right after the last interior one. The front end turns
// nodes into update jobs (none for the first node of a sweep, two for the surface
// node of a sweep of two or more nodes) and parks them in a four-entry queue. The
// back end works one job at a time through a shared 8-bit digit-serial multiplier,
// three steps per coefficient product: an interior or centre update needs the Fourier
// product alone, a surface update the convective product, a bracket step and then
// the Fourier product. The front end takes a word per cycle while the queue has room
// and no surface job is still pending. The last result flags whether every node of
// the sweep moved by at most tolerance. Configuration writes take effect at once and
// belong between sweeps, with the core drained.
module explicit_heat_conduction_sweep_core
  import ehcs_pkg::*;
#(
  parameter int TEMP_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [((TEMP_BITS > BI_BITS) ? TEMP_BITS : BI_BITS)-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [TEMP_BITS-1:0] in_node_temp,
  input  logic                        in_is_last_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [TEMP_BITS-1:0] out_new_temp,
  output logic                        out_last_of_sweep,
  output logic                        out_sweep_converged
);

  localparam int JOB_W = 3*TEMP_BITS + 1;

  logic [FO_BITS-1:0]          fo_r;
  logic [BI_BITS-1:0]          bi_r;
  logic signed [TEMP_BITS-1:0] tc_r;
  logic signed [TEMP_BITS-1:0] src_r;
  logic [TEMP_BITS-2:0]        tol_r;

  q_stat_t          q_stat;
  logic             q_push, q_pop;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fo_r  <= FO_BITS'(16384);
      bi_r  <= '0;
      tc_r  <= '0;
      src_r <= '0;
      tol_r <= (TEMP_BITS-1)'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOURIER: fo_r  <= cfg_wdata[FO_BITS-1:0];
        CFG_BIOT:    bi_r  <= cfg_wdata[BI_BITS-1:0];
        CFG_COOLANT: tc_r  <= cfg_wdata[TEMP_BITS-1:0];
        CFG_SOURCE:  src_r <= cfg_wdata[TEMP_BITS-1:0];
        CFG_TOL:     tol_r <= cfg_wdata[TEMP_BITS-2:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  ehcs_front #(
    .TEMP_BITS (TEMP_BITS),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_node_temp    (in_node_temp),
    .in_is_last_node (in_is_last_node),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  ehcs_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  ehcs_back #(
    .TEMP_BITS (TEMP_BITS),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_data              (q_rdata),
    .q_pop               (q_pop),
    .fourier             (fo_r),
    .biot                (bi_r),
    .coolant             (tc_r),
    .source              (src_r),
    .tol                 (tol_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_new_temp        (out_new_temp),
    .out_last_of_sweep   (out_last_of_sweep),
    .out_sweep_converged (out_sweep_converged)
  );

endmodule

@@ sim/tb_top.sv @@
// Testbench of the heat conduction sweep core: directed table, random sweeps, exact predictor.
`timescale 1ns / 100ps

module tb_top
  import ehcs_pkg::*;
();

  localparam int  TEMP_W        = 32;
  localparam int  WDATA_W       = (TEMP_W > BI_BITS) ? TEMP_W : BI_BITS;
  localparam int  SETTLE_CYCLES = 16;
  localparam int  TAIL_CYCLES   = 24;
  localparam int  REPORT_CAP    = 100;
  localparam int  PHASE_NODES   = 71;
  localparam int  TIMEOUT_NS    = 5_000_000;
  localparam longint TEMP_MAX   = 64'sd2147483647;
  localparam longint TEMP_MIN   = -64'sd2147483648;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic {ROW_NODE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [31:0]             value;
    logic                    last;
    logic                    typed;
    logic [31:0]             want_temp;
    logic                    want_conv;
  } stim_row_t;

  typedef struct packed {
    logic [TEMP_W-1:0] new_temp;
    logic              last_of_sweep;
    logic              converged;
  } node_update_t;

  // typed rows hold results under the reset settings or with Fourier at zero
  localparam int NUM_ROWS = 33;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_NODE, CFG_FOURIER, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
    '{ROW_NODE, CFG_FOURIER, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_NODE, CFG_FOURIER, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
    '{ROW_NODE, CFG_FOURIER, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0004_0000, 1'b1, 1'b1, 32'h0002_0000, 1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h8000_0000, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0001_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0001_8000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0001_0000, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_UNUSED,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_FOURIER, 32'h0000_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_BIOT,    32'h00FF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_COOLANT, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_SOURCE,  32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_TOL,     32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h1234_5678, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0000_0000, 1'b1, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_FOURIER, 32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_TOL,     32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'hDEAD_BEEF, 1'b1},
    '{ROW_REG,  CFG_FOURIER, 32'h0000_8000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_BIOT,    32'h0001_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_COOLANT, 32'h0064_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_SOURCE,  32'hFFFF_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_REG,  CFG_TOL,     32'h0000_8000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0032_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0050_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_NODE, CFG_FOURIER, 32'h0060_0000, 1'b1, 1'b0, 32'h0,         1'b0}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [WDATA_W-1:0]       cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [TEMP_W-1:0] in_node_temp;
  logic                     in_is_last_node;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [TEMP_W-1:0] out_new_temp;
  logic                     out_last_of_sweep;
  logic                     out_sweep_converged;

  // predictor settings and sweep state
  logic [FO_BITS-1:0]       fo_q;
  logic [BI_BITS-1:0]       bi_q;
  logic signed [TEMP_W-1:0] tc_q;
  logic signed [TEMP_W-1:0] src_q;
  logic [TEMP_W-2:0]        tol_q;
  longint                   inner_temp;
  longint                   pending_temp;
  int                       sweep_nodes;
  logic                     sweep_within;

  node_update_t awaited_updates [$];
  node_update_t want;

  int in_idle_pct;
  int out_idle_pct;
  int nodes_sent;
  int sweeps_closed;
  int updates_checked;
  int sweeps_converged;
  int mismatch_count;

  explicit_heat_conduction_sweep_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_node_temp        (in_node_temp),
    .in_is_last_node     (in_is_last_node),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_new_temp        (out_new_temp),
    .out_last_of_sweep   (out_last_of_sweep),
    .out_sweep_converged (out_sweep_converged)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(x * k / 2^16), halves toward +infinity
  function automatic longint q16_scale(input longint x, input logic [23:0] k);
    logic signed [127:0] wide_x;
    logic signed [127:0] wide_k;
    logic signed [127:0] prod;
    wide_x = x;
    wide_k = {104'd0, k};
    prod   = (wide_x * wide_k + 128'sd32768) >>> 16;
    return prod[63:0];
  endfunction

  function automatic longint sat_temp(input longint v);
    if (v > TEMP_MAX) return TEMP_MAX;
    if (v < TEMP_MIN) return TEMP_MIN;
    return v;
  endfunction

  function automatic longint interior_temp(input longint a, input longint m, input longint n);
    return m + q16_scale(a + n + longint'(src_q) - 2 * m, fo_q);
  endfunction

  function automatic longint surface_temp(input longint a, input longint m);
    longint conv;
    conv = q16_scale(2 * (longint'(tc_q) - m), bi_q);
    return m + q16_scale(2 * (a - m) + longint'(src_q) + conv, fo_q);
  endfunction

  function automatic void log_update(input longint raw, input longint old, input logic last);
    longint       t;
    longint       d;
    node_update_t u;
    t = sat_temp(raw);
    d = (t >= old) ? t - old : old - t;
    if (d > longint'({33'd0, tol_q})) sweep_within = 1'b0;
    u.new_temp      = t[TEMP_W-1:0];
    u.last_of_sweep = last;
    u.converged     = last & sweep_within;
    awaited_updates = {awaited_updates, u};
  endfunction

  function automatic void predict_node_updates(input logic signed [TEMP_W-1:0] word,
                                               input logic last);
    longint x;
    x = longint'(word);
    if (sweep_nodes == 0) begin
      if (last) begin
        // lone node: surface update with itself as inner neighbour
        log_update(surface_temp(x, x), x, 1'b1);
      end else begin
        pending_temp = x;
        sweep_nodes  = 1;
        return;
      end
    end else begin
      if (sweep_nodes == 1)
        log_update(interior_temp(x, pending_temp, x), pending_temp, 1'b0);
      else
        log_update(interior_temp(inner_temp, pending_temp, x), pending_temp, 1'b0);
      if (last) begin
        log_update(surface_temp(pending_temp, x), x, 1'b1);
      end else begin
        inner_temp   = pending_temp;
        pending_temp = x;
        sweep_nodes  = 2;
      end
    end
    if (last) begin
      sweep_nodes  = 0;
      sweep_within = 1'b1;
    end
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [WDATA_W-1:0] val);
    case (idx)
      CFG_FOURIER: fo_q  = val[FO_BITS-1:0];
      CFG_BIOT:    bi_q  = val[BI_BITS-1:0];
      CFG_COOLANT: tc_q  = val[TEMP_W-1:0];
      CFG_SOURCE:  src_q = val[TEMP_W-1:0];
      CFG_TOL:     tol_q = val[TEMP_W-2:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // drain the core, then write one register
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WDATA_W-1:0] val);
    in_valid <= 1'b0;
    while (awaited_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    store_setting(idx, val);
    cfg_we <= 1'b0;
  endtask

  // hold the word until taken; returns in the step of acceptance
  task automatic push_node(input logic [TEMP_W-1:0] word, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_node_temp    <= word;
    in_is_last_node <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_node_updates(word, last);
    nodes_sent++;
    if (last) sweeps_closed++;
  endtask

  task automatic random_settings();
    case ($urandom_range(4))
      0: write_reg(CFG_FOURIER, 32'd0);
      1: write_reg(CFG_FOURIER, 32'd32768);
      2: write_reg(CFG_FOURIER, 32'd65535);
      default: write_reg(CFG_FOURIER, $urandom_range(32768));
    endcase
    case ($urandom_range(3))
      0: write_reg(CFG_BIOT, 32'd0);
      1: write_reg(CFG_BIOT, 32'h00FF_FFFF);
      2: write_reg(CFG_BIOT, $urandom_range(131072));
      default: write_reg(CFG_BIOT, $urandom);
    endcase
    if ($urandom_range(1) == 0) write_reg(CFG_COOLANT, pick_extreme());
    else write_reg(CFG_COOLANT, int'($urandom_range(33554432)) - 16777216);
    if ($urandom_range(1) == 0) write_reg(CFG_SOURCE, pick_extreme());
    else write_reg(CFG_SOURCE, int'($urandom_range(524288)) - 262144);
    case ($urandom_range(3))
      0: write_reg(CFG_TOL, 32'd0);
      1: write_reg(CFG_TOL, 32'h7FFF_FFFF);
      2: write_reg(CFG_TOL, $urandom_range(1048576));
      default: write_reg(CFG_TOL, $urandom);
    endcase
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  // one whole sweep: mostly a smooth radial profile, some noise and extremes
  task automatic run_sweep();
    int unsigned len;
    int unsigned style;
    int          level;
    logic [31:0] word;
    len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    style = $urandom_range(19);
    level = int'($urandom_range(33554432)) - 16777216;
    for (int unsigned i = 1; i <= len; i++) begin
      if (style < 12) begin
        level += int'($urandom_range(262144)) - 131072;
        word = level;
      end else if (style < 17) begin
        word = $urandom;
      end else begin
        word = pick_extreme();
      end
      push_node(word, i == len);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // outputs settle between edges: check at the falling edge before acceptance
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_updates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: unexpected word, expected none, got temp %h last %b conv %b",
                   $time, out_new_temp, out_last_of_sweep, out_sweep_converged);
      end else begin
        want = awaited_updates.pop_front();
        if (out_new_temp !== want.new_temp || out_last_of_sweep !== want.last_of_sweep ||
            out_sweep_converged !== want.converged) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: word %0d mismatch, expected temp %h last %b conv %b, got temp %h last %b conv %b",
                     $time, updates_checked, want.new_temp, want.last_of_sweep, want.converged,
                     out_new_temp, out_last_of_sweep, out_sweep_converged);
        end
        updates_checked++;
      end
      if (out_last_of_sweep && out_sweep_converged) sweeps_converged++;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("explicit_heat_conduction_sweep_core test failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t    row;
    node_update_t typed_upd;
    int           phase_end;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_FOURIER;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_node_temp    <= '0;
    in_is_last_node <= 1'b0;
    in_idle_pct      = 11;
    out_idle_pct     = 48;
    nodes_sent       = 0;
    sweeps_closed    = 0;
    updates_checked  = 0;
    sweeps_converged = 0;
    mismatch_count   = 0;
    fo_q         = 16'd16384;
    bi_q         = '0;
    tc_q         = '0;
    src_q        = '0;
    tol_q        = 31'd65536;
    inner_temp   = 0;
    pending_temp = 0;
    sweep_nodes  = 0;
    sweep_within = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_idx, row.value);
      end else begin
        push_node(row.value, row.last);
        if (row.typed) begin
          typed_upd.new_temp      = row.want_temp;
          typed_upd.last_of_sweep = 1'b1;
          typed_upd.converged     = row.want_conv;
          awaited_updates[awaited_updates.size() - 1] = typed_upd;
        end
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin in_idle_pct = 11; out_idle_pct = 48; end
        1: begin in_idle_pct = 48; out_idle_pct = 11; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int p = 0; p < 4; p++) begin
        random_settings();
        phase_end = nodes_sent + PHASE_NODES;
        while (nodes_sent < phase_end) run_sweep();
      end
    end
    in_valid <= 1'b0;

    while (awaited_updates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d nodes in %0d sweeps over 12 random settings; checked %0d updates,",
             nodes_sent, sweeps_closed, updates_checked);
    $display("%0d sweeps reported converged, %0d mismatches.", sweeps_converged, mismatch_count);
    if (mismatch_count == 0)
      $display("explicit_heat_conduction_sweep_core test passed");
    else
      $display("explicit_heat_conduction_sweep_core test failed");
    $finish;
  end

endmodule
